FILE: sv/hmtd_pkg.sv
// Shared types, codes and constants for the humidity/temperature frame decoder.
// Used by every stage module and the top level; no dependencies.
`default_nettype none

package hmtd_pkg;

    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_HUMID = 2'd1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_KIND = 2'd2;

    localparam logic [7:0]  CRC_POLY_RESET  = 8'h31;
    localparam logic [7:0]  RAW_STATUS_MASK = 8'hFC;
    localparam logic [14:0] T_GAIN          = 15'd17572;
    localparam logic [14:0] H_GAIN          = 15'd12500;
    localparam logic [12:0] T_OFFS          = 13'd4685;
    localparam logic [12:0] H_OFFS          = 13'd600;

    // Stage 1 -> stage 2
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] msb;
        logic [7:0] lsb;
        logic [7:0] chk;
        logic [7:0] acc;
    } s1_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic [1:0]  status;
        logic        is_temp;
        logic [30:0] prod;
    } s2_t;

    // One CRC-8 byte update, MSB first
    function automatic logic [7:0] crc_byte_step(input logic [7:0] acc_in,
                                                 input logic [7:0] data,
                                                 input logic [7:0] poly);
        logic [7:0] acc;
        acc = acc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (acc[7])
                acc = {acc[6:0], 1'b0} ^ poly;
            else
                acc = {acc[6:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hmtd_crc_stage.sv
// Stage 1: register the frame and run the CRC over the first data byte.
// Depends on hmtd_pkg.
`default_nettype none

module hmtd_crc_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         poly,
    input  wire logic               up_valid,
    output logic                    up_stall,
    input  wire logic [1:0]         measure_kind,
    input  wire logic [7:0]         msb_byte,
    input  wire logic [7:0]         lsb_byte,
    input  wire logic [7:0]         crc_byte,
    output logic                    dn_valid,
    input  wire logic               dn_stall,
    output hmtd_pkg::s1_t           dn_data
);

    logic          valid_reg;
    hmtd_pkg::s1_t data_reg;
    hmtd_pkg::s1_t data_next;

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        data_next.kind = measure_kind;
        data_next.msb  = msb_byte;
        data_next.lsb  = lsb_byte;
        data_next.chk  = crc_byte;
        data_next.acc  = hmtd_pkg::crc_byte_step(8'h00, msb_byte, poly);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/hmtd_mul_stage.sv
// Stage 2: finish the CRC over the second byte, check it, and scale the raw value.
// Depends on hmtd_pkg.
`default_nettype none

module hmtd_mul_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         poly,
    input  wire logic               up_valid,
    output logic                    up_stall,
    input  wire hmtd_pkg::s1_t      up_data,
    output logic                    dn_valid,
    input  wire logic               dn_stall,
    output hmtd_pkg::s2_t           dn_data
);

    logic          valid_reg;
    hmtd_pkg::s2_t data_reg;
    hmtd_pkg::s2_t data_next;
    logic [7:0]    crc_final;
    logic [15:0]   raw;
    logic [14:0]   gain;

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        crc_final = hmtd_pkg::crc_byte_step(up_data.acc, up_data.lsb, poly);
        raw       = {up_data.msb, up_data.lsb & hmtd_pkg::RAW_STATUS_MASK};
        data_next.is_temp = (up_data.kind == hmtd_pkg::KIND_TEMP);
        gain = data_next.is_temp ? hmtd_pkg::T_GAIN : hmtd_pkg::H_GAIN;
        data_next.prod = {15'd0, raw} * {16'd0, gain};
        // unknown kind wins over a CRC mismatch
        if (up_data.kind != hmtd_pkg::KIND_TEMP && up_data.kind != hmtd_pkg::KIND_HUMID)
            data_next.status = hmtd_pkg::ST_KIND;
        else if (crc_final != up_data.chk)
            data_next.status = hmtd_pkg::ST_CRC;
        else
            data_next.status = hmtd_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/hmtd_out_stage.sv
// Stage 3: remove the offset, divide by 65536 rounding toward zero, hold the result.
// Depends on hmtd_pkg.
`default_nettype none

module hmtd_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_stall,
    input  wire hmtd_pkg::s2_t      up_data,
    output logic                    dn_valid,
    input  wire logic               dn_stall,
    output logic signed [14:0]      reading,
    output logic [1:0]              status
);

    logic               valid_reg;
    logic signed [14:0] reading_reg;
    logic signed [14:0] reading_next;
    logic [1:0]         status_reg;
    logic [12:0]        offs;
    logic [15:0]        diff;
    logic [15:0]        adj;

    assign up_stall = valid_reg && dn_stall;

    always_comb
    begin
        offs = up_data.is_temp ? hmtd_pkg::T_OFFS : hmtd_pkg::H_OFFS;
        // offset is a whole multiple of 65536, so the fraction is the product's low half
        diff = {1'b0, up_data.prod[30:16]} - {3'b000, offs};
        adj  = diff + {15'd0, (diff[15] && (up_data.prod[15:0] != 16'd0))};
        if (up_data.status == hmtd_pkg::ST_OK)
            reading_next = adj[14:0];
        else
            reading_next = 15'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            reading_reg <= reading_next;
            status_reg  <= up_data.status;
        end
    end

    assign dn_valid = valid_reg;
    assign reading  = reading_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

FILE: sv/humidity_temp_frame_decode.sv
// Top level of the humidity/temperature frame decoder: polynomial register and
// three pipeline stages. Depends on hmtd_pkg, hmtd_crc_stage, hmtd_mul_stage, hmtd_out_stage.
//
//   channel  handshake            payload
//   input    in_valid/in_stall    measure_kind, msb_byte, lsb_byte, crc_byte
//   output   out_valid/out_stall  reading, status
//   config   cfg_we               cfg_wdata (CRC polynomial)
//
// Each request is registered in stage 1, 2 and 3; one request per cycle while no stage stalls.
// Each stage holds when it is full and the stage after it stalls, so bubbles
// collapse and a held result does not block upstream stages that are empty.
// Reset clears all valid bits and loads the polynomial with 0x31.
`default_nettype none

module humidity_temp_frame_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         measure_kind,
    input  wire logic [7:0]         msb_byte,
    input  wire logic [7:0]         lsb_byte,
    input  wire logic [7:0]         crc_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [14:0]      reading,
    output logic [1:0]              status
);

    logic [7:0]    poly_reg;
    logic          s1_valid;
    logic          s1_stall;
    hmtd_pkg::s1_t s1_data;
    logic          s2_valid;
    logic          s2_stall;
    hmtd_pkg::s2_t s2_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_reg <= hmtd_pkg::CRC_POLY_RESET;
        else if (cfg_we)
            poly_reg <= cfg_wdata;
    end

    hmtd_crc_stage u_crc (
        .clk          (clk),
        .rst_n        (rst_n),
        .poly         (poly_reg),
        .up_valid     (in_valid),
        .up_stall     (in_stall),
        .measure_kind (measure_kind),
        .msb_byte     (msb_byte),
        .lsb_byte     (lsb_byte),
        .crc_byte     (crc_byte),
        .dn_valid     (s1_valid),
        .dn_stall     (s1_stall),
        .dn_data      (s1_data)
    );

    hmtd_mul_stage u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .poly     (poly_reg),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_stall (s2_stall),
        .dn_data  (s2_data)
    );

    hmtd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_stall (s2_stall),
        .up_data  (s2_data),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .reading  (reading),
        .status   (status)
    );

endmodule

`default_nettype wire
